// File: src/pcs_pkg.sv
// shared constants and types for the sundaram prime counter
`default_nettype none

package pcs_pkg;

    // default largest bound handled by the sieve
    localparam int unsigned MAX_N_DEF = 65535;

    // fixed port field widths
    localparam int unsigned LIMIT_W = 16;
    localparam int unsigned COUNT_W = 16;

    // entries in the job queue between front and back
    localparam int unsigned QUEUE_DEPTH = 2;

    // first row of the mark pass: i = 1 gives start 2i(i+1) and stride 2i+1
    localparam int unsigned ROW1_START  = 4;
    localparam int unsigned ROW1_STRIDE = 3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_MARK,
        ST_COUNT,
        ST_FINISH
    } back_state_t;

endpackage

`default_nettype wire

// File: src/pcs_front.sv
// input side: saturates the bound and turns it into a sieve job
`default_nettype none

module pcs_front #(
    parameter int unsigned MAX_N = pcs_pkg::MAX_N_DEF,
    parameter int unsigned AW    = $clog2(MAX_N / 2 + 1)
) (
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [pcs_pkg::LIMIT_W-1:0]  limit_n,
    input  wire logic                         q_full,
    output logic                              q_push,
    output logic [AW:0]                       q_data
);

    localparam int unsigned NW = $clog2(MAX_N + 1);
    localparam int unsigned EW = (NW > pcs_pkg::LIMIT_W) ? NW : pcs_pkg::LIMIT_W;
    localparam logic [EW-1:0] MAX_N_E = EW'(MAX_N);

    logic [EW-1:0] n_ext;
    logic [EW-1:0] n_sat;
    logic [EW-1:0] half;
    logic          has_two;

    always_comb
    begin
        n_ext   = EW'(limit_n);
        n_sat   = (n_ext > MAX_N_E) ? MAX_N_E : n_ext;
        // x = (n-1)/2, zero for n = 0
        half    = (n_sat == '0) ? '0 : ((n_sat - EW'(1)) >> 1);
        has_two = (n_sat >= EW'(2));
    end

    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;
    assign q_data   = {has_two, half[AW-1:0]};

endmodule

`default_nettype wire

// File: src/pcs_queue.sv
// small fifo of pending sieve jobs
`default_nettype none

module pcs_queue #(
    parameter int unsigned DW = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire logic [DW-1:0] push_data,
    output logic               full,
    input  wire logic          pop,
    output logic               empty,
    output logic [DW-1:0]      pop_data
);

    localparam int unsigned DEPTH = pcs_pkg::QUEUE_DEPTH;
    localparam int unsigned PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW    = $clog2(DEPTH + 1);

    logic [DW-1:0] slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic          do_push;
    logic          do_pop;

    assign full     = (fill_reg == CW'(DEPTH));
    assign empty    = (fill_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// File: src/pcs_back.sv
// sieve engine: clear, mark and count passes over the bitmap, plus result register
`default_nettype none

module pcs_back #(
    parameter int unsigned MAX_N = pcs_pkg::MAX_N_DEF,
    parameter int unsigned AW    = $clog2(MAX_N / 2 + 1)
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         q_empty,
    input  wire logic [AW:0]                  q_data,
    output logic                              q_pop,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic [pcs_pkg::COUNT_W-1:0]       prime_count
);

    localparam int unsigned DEPTH = MAX_N / 2 + 1;
    localparam int unsigned KW    = AW + 4;
    localparam int unsigned CW    = $clog2(MAX_N / 2 + 2);

    pcs_pkg::back_state_t state_reg, state_next;

    logic [AW-1:0]  x_reg, x_next;
    logic           two_reg, two_next;
    logic [AW:0]    addr_reg, addr_next;
    logic [KW-1:0]  k_reg, k_next;
    logic [KW-1:0]  start_reg, start_next;
    logic [KW-1:0]  stride_reg, stride_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           out_valid_reg, out_valid_next;
    logic [CW-1:0]  out_count_reg, out_count_next;

    logic           bitmap [DEPTH];
    logic           wr_en;
    logic [AW-1:0]  wr_addr;
    logic           wr_bit;
    logic           rd_en;
    logic           rd_bit_reg;
    logic           rd_vld_reg;

    logic [KW-1:0]  x_k;
    logic [KW-1:0]  start_step;

    assign x_k        = KW'(x_reg);
    assign start_step = start_reg + (stride_reg << 1) + KW'(2);

    always_comb
    begin
        state_next     = state_reg;
        x_next         = x_reg;
        two_next       = two_reg;
        addr_next      = addr_reg;
        k_next         = k_reg;
        start_next     = start_reg;
        stride_next    = stride_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        out_count_next = out_count_reg;
        q_pop          = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = addr_reg[AW-1:0];
        wr_bit         = 1'b0;
        rd_en          = 1'b0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        // tally unmarked entries as read data returns
        if (rd_vld_reg && !rd_bit_reg)
        begin
            count_next = count_reg + CW'(1);
        end

        unique case (state_reg)
            pcs_pkg::ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    x_next     = q_data[AW-1:0];
                    two_next   = q_data[AW];
                    addr_next  = '0;
                    state_next = pcs_pkg::ST_CLEAR;
                end
            end
            pcs_pkg::ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = addr_reg[AW-1:0];
                wr_bit  = 1'b0;
                if (addr_reg == (AW + 1)'(x_reg))
                begin
                    k_next      = KW'(pcs_pkg::ROW1_START);
                    start_next  = KW'(pcs_pkg::ROW1_START);
                    stride_next = KW'(pcs_pkg::ROW1_STRIDE);
                    state_next  = pcs_pkg::ST_MARK;
                end
                else
                begin
                    addr_next = addr_reg + (AW + 1)'(1);
                end
            end
            pcs_pkg::ST_MARK:
            begin
                if (k_reg <= x_k)
                begin
                    wr_en   = 1'b1;
                    wr_addr = k_reg[AW-1:0];
                    wr_bit  = 1'b1;
                    k_next  = k_reg + stride_reg;
                end
                else if (start_step > x_k)
                begin
                    // no further row starts inside the range
                    addr_next  = (AW + 1)'(1);
                    count_next = CW'(two_reg);
                    state_next = pcs_pkg::ST_COUNT;
                end
                else
                begin
                    start_next  = start_step;
                    k_next      = start_step;
                    stride_next = stride_reg + KW'(2);
                end
            end
            pcs_pkg::ST_COUNT:
            begin
                if (addr_reg <= (AW + 1)'(x_reg))
                begin
                    rd_en     = 1'b1;
                    addr_next = addr_reg + (AW + 1)'(1);
                end
                else
                begin
                    state_next = pcs_pkg::ST_FINISH;
                end
            end
            pcs_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_count_next = count_reg;
                    state_next     = pcs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pcs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pcs_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            rd_vld_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            rd_vld_reg    <= rd_en;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg         <= x_next;
        two_reg       <= two_next;
        addr_reg      <= addr_next;
        k_reg         <= k_next;
        start_reg     <= start_next;
        stride_reg    <= stride_next;
        count_reg     <= count_next;
        out_count_reg <= out_count_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            bitmap[wr_addr] <= wr_bit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_bit_reg <= bitmap[addr_reg[AW-1:0]];
        end
    end

    assign out_valid   = out_valid_reg;
    assign prime_count = pcs_pkg::COUNT_W'(out_count_reg);

endmodule

`default_nettype wire

// File: src/prime_count_sundaram_sieve.sv
// top level of the sundaram sieve prime counter
`default_nettype none

// channel  | beat fields       | handshake
// ---------+-------------------+----------------------
// input    | limit_n[15:0]     | in_valid / in_stall
// output   | prime_count[15:0] | out_valid / out_stall
//
// one beat in gives one beat out, in order. with x = (n-1)/2 a query runs
// a clear pass over entries 0..x, a mark pass row by row and a count pass
// over entries 1..x; the bitmap memory has one write port and one read port,
// so each pass handles one entry at a time.
// reset clears control state only; the bitmap is swept clear by each query.
// the input stalls only when the job queue is full; the engine holds a
// finished result in its output register until out_stall drops.

module prime_count_sundaram_sieve #(
    parameter int unsigned MAX_N = pcs_pkg::MAX_N_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [pcs_pkg::LIMIT_W-1:0]  limit_n,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic [pcs_pkg::COUNT_W-1:0]       prime_count
);

    // bitmap address width covers entries 0..MAX_N/2
    localparam int unsigned AW = $clog2(MAX_N / 2 + 1);

    // job word: {has_two, x}
    logic [AW:0] push_data;
    logic [AW:0] pop_data;
    logic        q_push;
    logic        q_full;
    logic        q_pop;
    logic        q_empty;

    // front: saturate the bound and derive x and the prime-two flag
    pcs_front #(
        .MAX_N (MAX_N),
        .AW    (AW)
    ) u_front (
        .in_valid (in_valid),
        .in_stall (in_stall),
        .limit_n  (limit_n),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (push_data)
    );

    // decouples beat acceptance from the long sieve run
    pcs_queue #(
        .DW (AW + 1)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .pop_data  (pop_data)
    );

    // back: clear, mark and count over the bitmap memory
    pcs_back #(
        .MAX_N (MAX_N),
        .AW    (AW)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_data      (pop_data),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .prime_count (prime_count)
    );

endmodule

`default_nettype wire

// File: verif/testbench.sv
// self-checking testbench for the sundaram sieve prime counter
`timescale 1ns / 100ps

module testbench;

    // largest bound the block is built for, and the last bitmap index it uses
    localparam int unsigned BOUND_MAX = pcs_pkg::MAX_N_DEF;
    localparam int unsigned ODD_LAST  = pcs_pkg::MAX_N_DEF / 2;

    // receiver stall behavior, picked per stretch of cycles
    typedef enum int unsigned {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY
    } stall_mode_t;

    // expected prime counts, one per accepted query, oldest first
    class prime_count_tracker;
        logic [pcs_pkg::COUNT_W-1:0] expected_counts[$];
        bit                          composite_odd[0:ODD_LAST];
        int unsigned                 mismatches;
        int unsigned                 checked;

        // sundaram sieve: index k left unmarked stands for the odd prime 2k+1
        function logic [pcs_pkg::COUNT_W-1:0] primes_up_to(
            logic [pcs_pkg::LIMIT_W-1:0] bound);
            int unsigned n;
            int unsigned x;
            int unsigned i;
            int unsigned j;
            int unsigned k;
            int unsigned total;
            n = 32'(bound);
            if (n > BOUND_MAX)
                n = BOUND_MAX;
            x = (n >= 1) ? (n - 1) / 2 : 0;
            if (x > ODD_LAST)
                x = ODD_LAST;
            for (k = 0; k <= x; k++)
                composite_odd[k] = 1'b0;
            for (i = 1; 2 * i * i + 2 * i <= x; i++)
                for (j = i; i + j + 2 * i * j <= x; j++)
                    composite_odd[i + j + 2 * i * j] = 1'b1;
            total = (n >= 2) ? 1 : 0;
            for (k = 1; k <= x; k++)
                if (!composite_odd[k])
                    total++;
            return total[pcs_pkg::COUNT_W-1:0];
        endfunction

        function void note_query(logic [pcs_pkg::LIMIT_W-1:0] bound);
            expected_counts.push_back(primes_up_to(bound));
        endfunction

        function int unsigned outstanding();
            return expected_counts.size();
        endfunction

        task report_mismatch(string what, logic [pcs_pkg::COUNT_W-1:0] got,
                             logic [pcs_pkg::COUNT_W-1:0] want);
            $display("[%0t] error: %s, got %0d want %0d", $time, what, got, want);
            mismatches++;
        endtask

        task check_count(logic [pcs_pkg::COUNT_W-1:0] got);
            logic [pcs_pkg::COUNT_W-1:0] want;
            if (expected_counts.size() == 0)
            begin
                report_mismatch("prime_count beat with no query pending", got, '0);
                return;
            end
            want = expected_counts.pop_front();
            checked++;
            if (got !== want)
                report_mismatch("prime_count differs", got, want);
        endtask
    endclass

    logic                         clk       = 1'b0;
    logic                         rst_n     = 1'b0;
    logic                         in_valid  = 1'b0;
    logic [pcs_pkg::LIMIT_W-1:0]  limit_n   = '0;
    logic                         out_stall = 1'b0;
    logic                         in_stall;
    logic                         out_valid;
    logic [pcs_pkg::COUNT_W-1:0]  prime_count;

    prime_count_tracker  tally = new;

    // sender burst state
    int unsigned         burst_left = 0;

    // receiver hold-off request from the main sequence, and its own counters
    int unsigned         holdoff_req  = 0;
    int unsigned         holdoff_left = 0;
    int unsigned         segment_left = 0;
    stall_mode_t         stall_mode   = STALL_NONE;

    // watchdog; the limit grows with every query offered
    longint unsigned     cycle_count = 0;
    longint unsigned     cycle_limit = 20000;

    // run statistics for the summary
    int unsigned         queries_sent  = 0;
    int unsigned         input_stalls  = 0;
    int unsigned         largest_bound = 0;

    // bounds, parities and small-n corners, plus a few large ones
    logic [pcs_pkg::LIMIT_W-1:0]  directed_bounds[25] = '{
        16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd6, 16'd7, 16'd8,
        16'd9, 16'd10, 16'd11, 16'd13, 16'd25, 16'd49, 16'd97, 16'd100,
        16'd127, 16'd128, 16'd255, 16'd256, 16'd1000, 16'd4096,
        16'd21845, 16'd65535
    };

    prime_count_sundaram_sieve u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .limit_n     (limit_n),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .prime_count (prime_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > cycle_limit)
        begin
            $display("timeout after %0d cycles, %0d counts still pending",
                     cycle_count, tally.outstanding());
            $display("FAILURE");
            $finish;
        end
    end

    // receiver: check the beat taken at this edge, then pick the next stall
    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
            tally.check_count(prime_count);

        // a requested hold-off overrides the random pattern
        if (holdoff_req != 0)
        begin
            holdoff_left = holdoff_req;
            holdoff_req  = 0;
        end

        if (holdoff_left != 0)
        begin
            out_stall <= 1'b1;
            holdoff_left--;
        end
        else
        begin
            if (segment_left == 0)
            begin
                stall_mode   = stall_mode_t'($urandom_range(STALL_NONE, STALL_HEAVY));
                segment_left = $urandom_range(20, 200);
            end
            segment_left--;
            case (stall_mode)
                STALL_NONE:  out_stall <= 1'b0;
                STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                default:     out_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // present one query and hold it until the block takes it; returns at the
    // edge of acceptance with valid still high
    task automatic send_query(input logic [pcs_pkg::LIMIT_W-1:0] bound);
        // budget for the clear, mark and count passes of this bound, with
        // slack for gaps and receiver stalls
        cycle_limit += 4 * (6 * longint'(bound / 2) + 500);
        in_valid <= 1'b1;
        limit_n  <= bound;
        @(posedge clk);
        while (in_stall)
        begin
            input_stalls++;
            @(posedge clk);
        end
        tally.note_query(bound);
        queries_sent++;
        if (32'(bound) > largest_bound)
            largest_bound = 32'(bound);
    endtask

    // sender with bursts of random length and random gaps between them
    task automatic offer_query(input logic [pcs_pkg::LIMIT_W-1:0] bound);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        send_query(bound);
    endtask

    // drop valid and wait for every pending count to come back
    task automatic drain_counts();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (tally.outstanding() != 0);
        burst_left = 0;
    endtask

    // mostly small bounds to keep the run short, now and then a wide one
    function automatic logic [pcs_pkg::LIMIT_W-1:0] random_bound();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 75)
            return pcs_pkg::LIMIT_W'($urandom_range(0, 511));
        else if (roll < 97)
            return pcs_pkg::LIMIT_W'($urandom_range(512, 4095));
        else
            return pcs_pkg::LIMIT_W'($urandom_range(4096, 16383));
    endfunction

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corners: n below 3, odd/even pairs, powers of two, the top
        foreach (directed_bounds[idx])
            offer_query(directed_bounds[idx]);
        drain_counts();

        // long receiver hold-off while small queries keep coming, so the job
        // queue and the output register fill and the input stalls
        holdoff_req  = 3000;
        cycle_limit += 4 * 3000;
        for (int q = 0; q < 8; q++)
            send_query(pcs_pkg::LIMIT_W'($urandom_range(0, 63)));
        drain_counts();

        // random part
        for (int q = 0; q < 70; q++)
            offer_query(random_bound());
        in_valid <= 1'b0;

        while (tally.outstanding() != 0)
            @(posedge clk);
        // let any stray beat show up before the verdict
        repeat (200) @(posedge clk);

        $display("%0d queries with bounds up to %0d, %0d counts checked",
                 queries_sent, largest_bound, tally.checked);
        $display("input held off for %0d cycles, %0d mismatches",
                 input_stalls, tally.mismatches);
        if (tally.mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
